[hw/rtl/psu_pkg.sv]
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and the paeth predictor for the png scanline
// unfilter block.
// ----------------------------------------------------------------------------
package psu_pkg;

   // register field widths
   localparam int WID_W = 13;
   localparam int HGT_W = 13;
   localparam int ROW_W = 12;
   localparam int RAW_W = WID_W + 2;
   localparam int MAX_HEIGHT = 4096;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W = 2;
   localparam logic [REG_IDX_W-1:0] REG_WIDTH = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ALPHA = 2'd2;

   // row filter types
   localparam logic [7:0] FLT_NONE = 8'd0;
   localparam logic [7:0] FLT_SUB = 8'd1;
   localparam logic [7:0] FLT_UP = 8'd2;
   localparam logic [7:0] FLT_AVG = 8'd3;
   localparam logic [7:0] FLT_PAETH = 8'd4;

   localparam logic [7:0] OPAQUE = 8'hFF;

   // result queue
   localparam int OUT_DEPTH = 3;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 2;

   // image geometry seen by the sequencer
   typedef struct packed {
      logic [HGT_W-1:0] height;
      logic             bpp4;
   } psu_geom_type;

   // one operation handed from the sequencer to the reconstruction stage
   typedef struct packed {
      logic       clear;
      logic       first_row;
      logic [7:0] filter;
      logic [7:0] sample;
      logic [1:0] lane;
      logic       emit;
      logic       bpp4;
      logic       row_last;
      logic       image_last;
   } psu_op_type;

   // one finished pixel
   typedef struct packed {
      logic [31:0] argb;
      logic        row_last;
      logic        image_last;
   } psu_pix_type;

   // paeth predictor on one byte lane
   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] p;
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [7:0]        pick;
      p = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
      da = p - $signed({2'b00, a});
      db = p - $signed({2'b00, b});
      dc = p - $signed({2'b00, c});
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) begin
         pick = a;
      end else if (db <= dc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

[hw/rtl/png_scanline_unfilter_argb.sv]
// ----------------------------------------------------------------------------
// png_scanline_unfilter_argb
// PNG row filter reconstruction (None, Sub, Up, Average, Paeth) for 8-bit
// RGB or RGBA streams, producing 32-bit ARGB pixels.
// ----------------------------------------------------------------------------
// The block takes one decompressed byte per cycle on req_ while the result
// queue has room: each byte reads the row store and each sample byte writes
// it, and the single read port and single write port set the pace. A pixel
// passes from the reconstruction stage register through the result queue
// to rsp_. req_tready drops only while the three-entry result queue is
// backed up by rsp_tready. The row store needs no clearing pass after reset:
// the first row of every image treats the row above as zero. The user must
// write csr_ configuration while no transaction is in flight; not enforced.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_argb import psu_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int ROW_BYTES = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   // input transaction
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [7:0] data_byte
   input  logic [0:0]            req_tuser,  // [0] frame_start
   // result transaction
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // [31:0] pixel_argb
   output logic                  rsp_tlast,  // row_last
   output logic [0:0]            rsp_tuser,  // [0] image_last
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int COL_W = $clog2(ROW_BYTES + 1);
   localparam int ADDR_W = $clog2(ROW_BYTES);

   psu_geom_type         geom;
   logic [COL_W-1:0]     stride;
   logic                 accept;
   logic                 op_valid;
   psu_op_type           op;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 emit_pending;
   logic                 pix_valid;
   psu_pix_type          pix;
   logic [OUT_CNT_W-1:0] fifo_count;
   logic [OUT_CNT_W:0]   committed;

   // room for the pixel in flight and one more
   assign committed = {1'b0, fifo_count} + {{OUT_CNT_W{1'b0}}, emit_pending};
   assign req_tready = (32'(committed) < OUT_DEPTH);
   assign accept = req_tvalid && req_tready;

   psu_cfg #(
      .MAX_WIDTH (MAX_WIDTH),
      .ROW_BYTES (ROW_BYTES),
      .COL_W     (COL_W)
   ) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .geom        (geom),
      .stride      (stride)
   );

   psu_ctrl #(
      .COL_W  (COL_W),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_tdata),
      .frame_start (req_tuser[0]),
      .geom        (geom),
      .stride      (stride),
      .op_valid    (op_valid),
      .op          (op),
      .rd_addr     (rd_addr)
   );

   psu_recon #(
      .ROW_BYTES (ROW_BYTES),
      .ADDR_W    (ADDR_W)
   ) u_recon (
      .clock        (clock),
      .reset        (reset),
      .op_valid     (op_valid),
      .op           (op),
      .rd_addr      (rd_addr),
      .emit_pending (emit_pending),
      .pix_valid    (pix_valid),
      .pix          (pix)
   );

   psu_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (pix_valid),
      .push_data  (pix),
      .count      (fifo_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[hw/rtl/psu_cfg.sv]
// ----------------------------------------------------------------------------
// psu_cfg
// Register file behind the csr port, plus the clamped row stride and height
// derived from it.
// ----------------------------------------------------------------------------
module psu_cfg import psu_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int ROW_BYTES = 16384,
   parameter int COL_W = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output psu_geom_type          geom,
   output logic [COL_W-1:0]      stride
);

   localparam logic [COL_W-1:0] CAP3 = COL_W'((ROW_BYTES / 3) * 3);
   localparam logic [COL_W-1:0] CAP4 = COL_W'((ROW_BYTES / 4) * 4);
   localparam logic [COL_W-1:0] RST_STRIDE = COL_W'(3);

   logic [WID_W-1:0]     width_ff, width_in;
   logic [HGT_W-1:0]     height_ff, height_in;
   logic                 alpha_ff, alpha_in;
   logic [COL_W-1:0]     stride_ff, stride_in;
   logic [HGT_W-1:0]     heff_ff, heff_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;
   logic [WID_W-1:0]     w1, w2;
   logic [RAW_W-1:0]     raw;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      alpha_in = alpha_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_WIDTH: width_in = csr_pwdata[WID_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[HGT_W-1:0];
            REG_ALPHA: alpha_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // clamp width and height, stride in bytes per row
   always_comb begin
      w1 = (width_in == '0) ? WID_W'(1) : width_in;
      w2 = (32'(w1) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : w1;
      if (alpha_in) begin
         raw = {w2, 2'b00};
      end else begin
         raw = {1'b0, w2, 1'b0} + {2'b00, w2};
      end
      if (32'(raw) > ROW_BYTES) begin
         stride_in = alpha_in ? CAP4 : CAP3;
      end else begin
         stride_in = COL_W'(raw);
      end
      if (height_in == '0) begin
         heff_in = HGT_W'(1);
      end else if (32'(height_in) > MAX_HEIGHT) begin
         heff_in = HGT_W'(MAX_HEIGHT);
      end else begin
         heff_in = height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WID_W'(1);
         height_ff <= HGT_W'(1);
         alpha_ff <= 1'b0;
         stride_ff <= RST_STRIDE;
         heff_ff <= HGT_W'(1);
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         alpha_ff <= alpha_in;
         stride_ff <= stride_in;
         heff_ff <= heff_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_WIDTH: csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_ALPHA: csr_prdata = CSR_DATA_W'(alpha_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign geom.height = heff_ff;
   assign geom.bpp4 = alpha_ff;
   assign stride = stride_ff;

endmodule

[hw/rtl/psu_ctrl.sv]
// ----------------------------------------------------------------------------
// psu_ctrl
// Column and row sequencer: tracks filter bytes, byte column, row count and
// first row, and issues one operation with its row store address per byte.
// ----------------------------------------------------------------------------
module psu_ctrl import psu_pkg::*; #(
   parameter int COL_W = 15,
   parameter int ADDR_W = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              frame_start,
   input  psu_geom_type      geom,
   input  logic [COL_W-1:0]  stride,
   output logic              op_valid,
   output psu_op_type        op,
   output logic [ADDR_W-1:0] rd_addr
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             first_ff, first_in;
   logic [7:0]       filter_ff, filter_in;
   logic [1:0]       k3_ff, k3_in;
   logic [COL_W-1:0] col_m1;
   logic [ROW_W-1:0] row_next;
   logic [HGT_W-1:0] row_plus;
   logic [1:0]       lane;
   logic             emit;
   logic             end_row;
   logic             start_row;

   assign col_m1 = col_ff - COL_W'(1);
   assign row_next = row_ff + ROW_W'(1);
   assign row_plus = {1'b0, row_ff} + HGT_W'(1);
   assign lane = geom.bpp4 ? col_m1[1:0] : k3_ff;
   assign emit = geom.bpp4 ? (lane == 2'd3) : (lane == 2'd2);
   assign end_row = (col_ff >= stride);
   assign rd_addr = col_m1[ADDR_W-1:0];
   assign op_valid = accept;

   // next state for one accepted byte
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      first_in = first_ff;
      filter_in = filter_ff;
      k3_in = k3_ff;
      start_row = 1'b0;
      op.clear = 1'b0;
      op.first_row = first_ff;
      op.filter = filter_ff;
      op.sample = data_byte;
      op.lane = lane;
      op.emit = 1'b0;
      op.bpp4 = geom.bpp4;
      op.row_last = 1'b0;
      op.image_last = 1'b0;
      if (frame_start) begin
         row_in = '0;
         first_in = 1'b1;
         start_row = 1'b1;
      end else if (col_ff == '0) begin
         start_row = 1'b1;
      end else if (col_ff > stride) begin
         // row cut short by a width change: count it done
         if ({1'b0, row_next} >= geom.height) begin
            row_in = '0;
            first_in = 1'b1;
         end else begin
            row_in = row_next;
            first_in = 1'b0;
         end
         start_row = 1'b1;
      end else begin
         col_in = col_ff + COL_W'(1);
         k3_in = (k3_ff == 2'd2) ? 2'd0 : k3_ff + 2'd1;
         op.emit = emit;
         if (emit && end_row) begin
            col_in = '0;
            op.row_last = 1'b1;
            if (row_plus >= geom.height) begin
               op.image_last = 1'b1;
               row_in = '0;
               first_in = 1'b1;
            end else begin
               row_in = row_next;
               first_in = 1'b0;
            end
         end
      end
      if (start_row) begin
         filter_in = data_byte;
         col_in = COL_W'(1);
         k3_in = 2'd0;
         op.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         first_ff <= 1'b1;
         filter_ff <= FLT_NONE;
         k3_ff <= 2'd0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         first_ff <= first_in;
         filter_ff <= filter_in;
         k3_ff <= k3_in;
      end
   end

endmodule

[hw/rtl/psu_recon.sv]
// ----------------------------------------------------------------------------
// psu_recon
// Row store memory and the filter reconstruction stage: reads the upper byte,
// predicts, adds, writes the byte back and assembles pixels.
// ----------------------------------------------------------------------------
module psu_recon import psu_pkg::*; #(
   parameter int ROW_BYTES = 16384,
   parameter int ADDR_W = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   input  psu_op_type        op,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              emit_pending,
   output logic              pix_valid,
   output psu_pix_type       pix
);

   logic [7:0]        row_mem [ROW_BYTES];
   logic              s1_valid_ff;
   psu_op_type        s1_op_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [7:0]        rd_q_ff;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [7:0]        fwd_data_ff;
   logic [31:0]       left_ff, left_in;
   logic [31:0]       upleft_ff, upleft_in;
   logic [23:0]       gather_ff, gather_in;
   logic [4:0]        lsb;
   logic [7:0]        a, b, c;
   logic [8:0]        avg_sum;
   logic [7:0]        pred;
   logic [7:0]        val;
   logic              wr_en;

   assign lsb = {s1_op_ff.lane, 3'b000};
   assign wr_en = s1_valid_ff && !s1_op_ff.clear;

   // row store, one read and one write per cycle
   always_ff @(posedge clock) begin
      if (op_valid) begin
         rd_q_ff <= row_mem[rd_addr];
      end
      if (wr_en) begin
         row_mem[s1_addr_ff] <= val;
      end
   end

   // a write landing on the address being read is forwarded
   assign fwd_hit_in = op_valid && wr_en && (s1_addr_ff == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         s1_valid_ff <= op_valid;
         fwd_hit_ff <= fwd_hit_in;
      end
      s1_op_ff <= op;
      s1_addr_ff <= rd_addr;
      fwd_data_ff <= val;
   end

   // predictor inputs
   assign a = left_ff[lsb +: 8];
   assign c = upleft_ff[lsb +: 8];
   assign b = s1_op_ff.first_row ? 8'd0 : (fwd_hit_ff ? fwd_data_ff : rd_q_ff);
   assign avg_sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (s1_op_ff.filter)
         FLT_NONE: pred = 8'd0;
         FLT_SUB: pred = a;
         FLT_UP: pred = b;
         FLT_AVG: pred = avg_sum[8:1];
         FLT_PAETH: pred = paeth_pick(a, b, c);
         default: pred = 8'd0;
      endcase
   end

   assign val = s1_op_ff.sample + pred;

   // left, upper left and pixel gather update
   always_comb begin
      left_in = left_ff;
      upleft_in = upleft_ff;
      gather_in = gather_ff;
      if (s1_valid_ff) begin
         if (s1_op_ff.clear) begin
            left_in = '0;
            upleft_in = '0;
            gather_in = '0;
         end else begin
            left_in[lsb +: 8] = val;
            upleft_in[lsb +: 8] = b;
            gather_in = s1_op_ff.emit ? 24'd0 : {gather_ff[15:0], val};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         upleft_ff <= '0;
         gather_ff <= '0;
      end else begin
         left_ff <= left_in;
         upleft_ff <= upleft_in;
         gather_ff <= gather_in;
      end
   end

   // finished pixel
   assign emit_pending = s1_valid_ff && s1_op_ff.emit;
   assign pix_valid = wr_en && s1_op_ff.emit;
   assign pix.argb = s1_op_ff.bpp4 ? {val, gather_ff} : {OPAQUE, gather_ff[15:0], val};
   assign pix.row_last = s1_op_ff.row_last;
   assign pix.image_last = s1_op_ff.image_last;

endmodule

[hw/rtl/psu_out_fifo.sv]
// ----------------------------------------------------------------------------
// psu_out_fifo
// Small result queue that decouples the reconstruction stage from the
// result channel.
// ----------------------------------------------------------------------------
module psu_out_fifo import psu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  psu_pix_type          push_data,
   output logic [OUT_CNT_W-1:0] count,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic                 rsp_tlast,
   output logic [0:0]           rsp_tuser
);

   localparam logic [OUT_PTR_W-1:0] PTR_LAST = OUT_PTR_W'(OUT_DEPTH - 1);
   localparam logic [OUT_CNT_W-1:0] CNT_FULL = OUT_CNT_W'(OUT_DEPTH);

   psu_pix_type          slot_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   psu_pix_type          head;

   assign head = slot_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata = head.argb;
   assign rsp_tlast = head.row_last;
   assign rsp_tuser = head.image_last;
   assign pop = rsp_tvalid && rsp_tready;
   assign count = count_ff;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + OUT_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + OUT_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + OUT_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   // no push into a full queue unless a pixel pops in the same cycle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff != CNT_FULL))
      else $error("result queue overflow");

   // empty queue has both pointers together
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("result queue pointers disagree with count");

   // a pixel pushed into an empty queue shows up at the head next cycle
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == '0) |=> (rsp_tvalid && rsp_tdata == $past(push_data.argb)))
      else $error("result queue lost a pixel");
`endif

endmodule
